// File: src/brdr_pkg.sv
package brdr_pkg;

   // Button count and per-button counter geometry
   localparam int BUTTONS    = 16;
   localparam int IDX_W      = $clog2(BUTTONS);
   localparam int CNT_W      = 16;
   localparam int DIV_CNT_W  = $clog2(CNT_W);
   localparam logic [CNT_W-1:0] HOLD_MAX = {CNT_W{1'b1}};

   typedef logic [BUTTONS-1:0] mask_type;
   typedef logic [CNT_W-1:0]   count_type;

   // Item kinds
   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_CLEAR = 1'b1;

   // Register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_START_DELAY = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DOWN_MASK   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_MASK   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_MASK  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_UP_MASK     = 3'd5;

   // Register reset values
   localparam logic [15:0] RST_START_DELAY = 16'd20;
   localparam logic [15:0] RST_PERIOD      = 16'd5;
   localparam logic [15:0] RST_DOWN_MASK   = 16'd1;
   localparam logic [15:0] RST_LEFT_MASK   = 16'd2;
   localparam logic [15:0] RST_RIGHT_MASK  = 16'd4;
   localparam logic [15:0] RST_UP_MASK     = 16'd8;

   // Numpad direction codes
   typedef logic [3:0] dir_type;
   localparam dir_type DIR_NONE       = 4'd0;
   localparam dir_type DIR_DOWN_LEFT  = 4'd1;
   localparam dir_type DIR_DOWN       = 4'd2;
   localparam dir_type DIR_DOWN_RIGHT = 4'd3;
   localparam dir_type DIR_LEFT       = 4'd4;
   localparam dir_type DIR_RIGHT      = 4'd6;
   localparam dir_type DIR_UP_LEFT    = 4'd7;
   localparam dir_type DIR_UP         = 4'd8;
   localparam dir_type DIR_UP_RIGHT   = 4'd9;

endpackage

// File: src/button_repeat_and_direction_resolver_top.sv
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_ready   req_kind, req_pressed_buttons
// rsp_      out        rsp_valid/rsp_ready   masks, rsp_dir_four, rsp_dir_eight
// csr_      in         csr_valid/csr_ready   csr_index, csr_data
//
// Steps: a tick item reads each button's press time from memory, then updates
// and writes it back; a button whose press time needs the repeat-period
// remainder then runs the bit-serial remainder unit. A finish step follows.
// A clear item zeroes the press-time memory, then finishes.
// Reset: a clearing pass zeroes the press-time memory; no item is taken
// meanwhile. Configuration writes are taken every cycle.
// Stalls: the result sits in an output register; a new item is taken while it
// waits, and only the finish cycle waits for the register to free.
module button_repeat_and_direction_resolver_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [15:0] req_pressed_buttons,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_held_mask,
   output logic [15:0] rsp_triggered_mask,
   output logic [15:0] rsp_repeated_mask,
   output logic [15:0] rsp_released_mask,
   output logic [3:0]  rsp_dir_four,
   output logic [3:0]  rsp_dir_eight,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam logic [2:0] ST_INIT   = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_READ   = 3'd2;
   localparam logic [2:0] ST_UPDATE = 3'd3;
   localparam logic [2:0] ST_DIVIDE = 3'd4;
   localparam logic [2:0] ST_CLEAR  = 3'd5;
   localparam logic [2:0] ST_FINISH = 3'd6;

   // Control state
   logic [2:0]                       state_ff, state_in;
   logic [brdr_pkg::IDX_W-1:0]       idx_ff, idx_in;
   logic [brdr_pkg::DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic                             rsp_valid_ff, rsp_valid_in;

   // Configuration
   logic [15:0] delay_ff, delay_in;
   logic [15:0] period_ff, period_in;
   logic [15:0] down_mask_ff, down_mask_in;
   logic [15:0] left_mask_ff, left_mask_in;
   logic [15:0] right_mask_ff, right_mask_in;
   logic [15:0] up_mask_ff, up_mask_in;

   // Per-item work registers
   brdr_pkg::mask_type  pressed_ff, pressed_in;
   brdr_pkg::mask_type  held_ff, held_in;
   brdr_pkg::mask_type  trig_ff, trig_in;
   brdr_pkg::mask_type  rep_ff, rep_in;
   brdr_pkg::mask_type  rel_ff, rel_in;
   brdr_pkg::count_type s2_ff, s2_in, s4_ff, s4_in, s6_ff, s6_in, s8_ff, s8_in;
   brdr_pkg::count_type t_ff, t_in;
   brdr_pkg::count_type rem_ff, rem_in;

   // Output register
   brdr_pkg::mask_type out_held_ff, out_held_in;
   brdr_pkg::mask_type out_trig_ff, out_trig_in;
   brdr_pkg::mask_type out_rep_ff, out_rep_in;
   brdr_pkg::mask_type out_rel_ff, out_rel_in;
   brdr_pkg::dir_type  out_d4_ff, out_d4_in;
   brdr_pkg::dir_type  out_d8_ff, out_d8_in;

   // Press-time memory
   brdr_pkg::count_type hold_mem [brdr_pkg::BUTTONS];
   brdr_pkg::count_type rdata_ff;
   logic                mem_we;
   brdr_pkg::count_type mem_wdata;

   // Datapath helpers
   logic                down;
   brdr_pkg::count_type t_new;
   logic                need_div;
   logic                last;
   logic [16:0]         step;
   brdr_pkg::count_type rem_step;
   brdr_pkg::dir_type   d4, d8;
   logic                nz2, nz4, nz6, nz8;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_held_mask      = out_held_ff;
   assign rsp_triggered_mask = out_trig_ff;
   assign rsp_repeated_mask  = out_rep_ff;
   assign rsp_released_mask  = out_rel_ff;
   assign rsp_dir_four       = out_d4_ff;
   assign rsp_dir_eight      = out_d8_ff;

   // Read every cycle at the sweep index; write back at the same index.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hold_mem[idx_ff] <= mem_wdata;
      end
      rdata_ff <= hold_mem[idx_ff];
   end

   // Next press time: count up to saturation while down, drop to zero on release.
   always_comb begin
      down = pressed_ff[idx_ff];
      if (!down) begin
         t_new = '0;
      end else if (rdata_ff == brdr_pkg::HOLD_MAX) begin
         t_new = rdata_ff;
      end else begin
         t_new = rdata_ff + brdr_pkg::count_type'(1);
      end
      need_div = (t_new > brdr_pkg::count_type'(1)) && (period_ff != '0) &&
                 (t_new >= delay_ff);
      last = (idx_ff == brdr_pkg::IDX_W'(brdr_pkg::BUTTONS - 1));
   end

   // One restoring remainder step: shift in the next bit of the press time.
   always_comb begin
      step = {rem_ff, t_ff[div_cnt_ff]};
      if (step >= {1'b0, period_ff}) begin
         rem_step = brdr_pkg::count_type'(step - {1'b0, period_ff});
      end else begin
         rem_step = step[15:0];
      end
   end

   // Direction resolve from the four group scores.
   always_comb begin
      nz2 = (s2_ff != '0);
      nz4 = (s4_ff != '0);
      nz6 = (s6_ff != '0);
      nz8 = (s8_ff != '0);
      d4  = brdr_pkg::DIR_NONE;
      d8  = brdr_pkg::DIR_NONE;
      if (!(nz2 && nz8) && !(nz4 && nz6)) begin
         // Shortest non-zero press wins; ties go to the lower code.
         if (nz2) begin
            d4 = brdr_pkg::DIR_DOWN;
         end
         if (nz4 && (!nz2 || s4_ff < s2_ff)) begin
            d4 = brdr_pkg::DIR_LEFT;
         end
         if (nz6 && (!nz2 || s6_ff < s2_ff) && (!nz4 || s6_ff < s4_ff)) begin
            d4 = brdr_pkg::DIR_RIGHT;
         end
         if (nz8 && (!nz4 || s8_ff < s4_ff) && (!nz6 || s8_ff < s6_ff)) begin
            d4 = brdr_pkg::DIR_UP;
         end
         // Diagonal priority: up-right, up-left, down-right, down-left.
         if (nz8 && nz6) begin
            d8 = brdr_pkg::DIR_UP_RIGHT;
         end else if (nz8 && nz4) begin
            d8 = brdr_pkg::DIR_UP_LEFT;
         end else if (nz2 && nz6) begin
            d8 = brdr_pkg::DIR_DOWN_RIGHT;
         end else if (nz2 && nz4) begin
            d8 = brdr_pkg::DIR_DOWN_LEFT;
         end else begin
            d8 = d4;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      div_cnt_in    = div_cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      delay_in      = delay_ff;
      period_in     = period_ff;
      down_mask_in  = down_mask_ff;
      left_mask_in  = left_mask_ff;
      right_mask_in = right_mask_ff;
      up_mask_in    = up_mask_ff;
      pressed_in    = pressed_ff;
      held_in       = held_ff;
      trig_in       = trig_ff;
      rep_in        = rep_ff;
      rel_in        = rel_ff;
      s2_in         = s2_ff;
      s4_in         = s4_ff;
      s6_in         = s6_ff;
      s8_in         = s8_ff;
      t_in          = t_ff;
      rem_in        = rem_ff;
      out_held_in   = out_held_ff;
      out_trig_in   = out_trig_ff;
      out_rep_in    = out_rep_ff;
      out_rel_in    = out_rel_ff;
      out_d4_in     = out_d4_ff;
      out_d8_in     = out_d8_ff;
      mem_we        = 1'b0;
      mem_wdata     = '0;

      // Configuration writes
      if (csr_valid) begin
         case (csr_index)
            brdr_pkg::CSR_START_DELAY: delay_in      = csr_data;
            brdr_pkg::CSR_PERIOD:      period_in     = csr_data;
            brdr_pkg::CSR_DOWN_MASK:   down_mask_in  = csr_data;
            brdr_pkg::CSR_LEFT_MASK:   left_mask_in  = csr_data;
            brdr_pkg::CSR_RIGHT_MASK:  right_mask_in = csr_data;
            brdr_pkg::CSR_UP_MASK:     up_mask_in    = csr_data;
            default: ;
         endcase
      end

      // Drop the result once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff) inside
         ST_INIT, ST_CLEAR: begin
            // Zero one counter per cycle
            mem_we = 1'b1;
            idx_in = idx_ff + brdr_pkg::IDX_W'(1);
            if (last) begin
               idx_in   = '0;
               state_in = (state_ff == ST_INIT) ? ST_IDLE : ST_FINISH;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               pressed_in = req_pressed_buttons;
               held_in    = '0;
               trig_in    = '0;
               rep_in     = '0;
               rel_in     = '0;
               s2_in      = '0;
               s4_in      = '0;
               s6_in      = '0;
               s8_in      = '0;
               idx_in     = '0;
               state_in   = (req_kind == brdr_pkg::KIND_CLEAR) ? ST_CLEAR : ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            mem_we          = 1'b1;
            mem_wdata       = t_new;
            t_in            = t_new;
            held_in[idx_ff] = (t_new != '0);
            trig_in[idx_ff] = (t_new == brdr_pkg::count_type'(1));
            rep_in[idx_ff]  = (t_new == brdr_pkg::count_type'(1));
            rel_in[idx_ff]  = !down && (rdata_ff != '0);
            if (down_mask_ff[idx_ff] && t_new > s2_ff) begin
               s2_in = t_new;
            end
            if (left_mask_ff[idx_ff] && t_new > s4_ff) begin
               s4_in = t_new;
            end
            if (right_mask_ff[idx_ff] && t_new > s6_ff) begin
               s6_in = t_new;
            end
            if (up_mask_ff[idx_ff] && t_new > s8_ff) begin
               s8_in = t_new;
            end
            if (need_div) begin
               rem_in     = '0;
               div_cnt_in = brdr_pkg::DIV_CNT_W'(brdr_pkg::CNT_W - 1);
               state_in   = ST_DIVIDE;
            end else if (last) begin
               idx_in   = '0;
               state_in = ST_FINISH;
            end else begin
               idx_in   = idx_ff + brdr_pkg::IDX_W'(1);
               state_in = ST_READ;
            end
         end
         ST_DIVIDE: begin
            rem_in     = rem_step;
            div_cnt_in = div_cnt_ff - brdr_pkg::DIV_CNT_W'(1);
            if (div_cnt_ff == '0) begin
               rep_in[idx_ff] = (rem_step == '0);
               if (last) begin
                  idx_in   = '0;
                  state_in = ST_FINISH;
               end else begin
                  idx_in   = idx_ff + brdr_pkg::IDX_W'(1);
                  state_in = ST_READ;
               end
            end
         end
         ST_FINISH: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               out_held_in  = held_ff;
               out_trig_in  = trig_ff;
               out_rep_in   = rep_ff;
               out_rel_in   = rel_ff;
               out_d4_in    = d4;
               out_d8_in    = d8;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         idx_ff        <= '0;
         div_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         delay_ff      <= brdr_pkg::RST_START_DELAY;
         period_ff     <= brdr_pkg::RST_PERIOD;
         down_mask_ff  <= brdr_pkg::RST_DOWN_MASK;
         left_mask_ff  <= brdr_pkg::RST_LEFT_MASK;
         right_mask_ff <= brdr_pkg::RST_RIGHT_MASK;
         up_mask_ff    <= brdr_pkg::RST_UP_MASK;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         div_cnt_ff    <= div_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         delay_ff      <= delay_in;
         period_ff     <= period_in;
         down_mask_ff  <= down_mask_in;
         left_mask_ff  <= left_mask_in;
         right_mask_ff <= right_mask_in;
         up_mask_ff    <= up_mask_in;
      end
   end

   always_ff @(posedge clock) begin
      pressed_ff  <= pressed_in;
      held_ff     <= held_in;
      trig_ff     <= trig_in;
      rep_ff      <= rep_in;
      rel_ff      <= rel_in;
      s2_ff       <= s2_in;
      s4_ff       <= s4_in;
      s6_ff       <= s6_in;
      s8_ff       <= s8_in;
      t_ff        <= t_in;
      rem_ff      <= rem_in;
      out_held_ff <= out_held_in;
      out_trig_ff <= out_trig_in;
      out_rep_ff  <= out_rep_in;
      out_rel_ff  <= out_rel_in;
      out_d4_ff   <= out_d4_in;
      out_d8_ff   <= out_d8_in;
   end

endmodule

// File: src/brdr_checker.sv
module brdr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_held_mask,
   input logic [15:0] rsp_triggered_mask,
   input logic [15:0] rsp_repeated_mask,
   input logic [3:0]  rsp_dir_four,
   input logic [3:0]  rsp_dir_eight
);

   // Hold a result until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before it was taken");

   // A first-frame button is held and repeats
   a_trig_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_triggered_mask & ~rsp_held_mask) == 16'd0))
      else $error("triggered button not held");

   a_trig_rep: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_triggered_mask & ~rsp_repeated_mask) == 16'd0))
      else $error("triggered button did not repeat");

   // The 4-way result is an orthogonal code or none
   a_dir_four: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_dir_four == brdr_pkg::DIR_NONE ||
                     rsp_dir_four == brdr_pkg::DIR_DOWN ||
                     rsp_dir_four == brdr_pkg::DIR_LEFT ||
                     rsp_dir_four == brdr_pkg::DIR_RIGHT ||
                     rsp_dir_four == brdr_pkg::DIR_UP))
      else $error("bad 4-way direction");

   // Both directions resolve together or not at all
   a_dir_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_dir_four == brdr_pkg::DIR_NONE) ==
                     (rsp_dir_eight == brdr_pkg::DIR_NONE)))
      else $error("4-way and 8-way directions disagree");

endmodule

bind button_repeat_and_direction_resolver_top brdr_checker u_brdr_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_held_mask      (rsp_held_mask),
   .rsp_triggered_mask (rsp_triggered_mask),
   .rsp_repeated_mask  (rsp_repeated_mask),
   .rsp_dir_four       (rsp_dir_four),
   .rsp_dir_eight      (rsp_dir_eight)
);

// File: tb/brdr_frame_checker.sv
`timescale 1ns / 100ps
module brdr_frame_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic                           req_kind,
   input  brdr_pkg::mask_type             req_pressed_buttons,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  brdr_pkg::mask_type             rsp_held_mask,
   input  brdr_pkg::mask_type             rsp_triggered_mask,
   input  brdr_pkg::mask_type             rsp_repeated_mask,
   input  brdr_pkg::mask_type             rsp_released_mask,
   input  brdr_pkg::dir_type              rsp_dir_four,
   input  brdr_pkg::dir_type              rsp_dir_eight,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [brdr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]                    csr_data,
   output int unsigned                    mismatch_total,
   output int unsigned                    frames_in_flight
);

   typedef struct packed {
      brdr_pkg::mask_type held;
      brdr_pkg::mask_type triggered;
      brdr_pkg::mask_type repeated;
      brdr_pkg::mask_type released;
      brdr_pkg::dir_type  dir_four;
      brdr_pkg::dir_type  dir_eight;
   } frame_report_type;

   brdr_pkg::count_type hold_frames [brdr_pkg::BUTTONS];
   logic [15:0]         start_delay, repeat_every;
   logic [15:0]         down_set, left_set, right_set, up_set;
   frame_report_type    expected_reports [$];
   int unsigned         fail_count;
   int unsigned         report_seq;

   // longest press among the buttons of one direction group
   function automatic brdr_pkg::count_type group_peak(input logic [15:0] group);
      brdr_pkg::count_type peak;
      int                  b;
      peak = '0;
      for (b = 0; b < brdr_pkg::BUTTONS; b++)
         if (group[b] && hold_frames[b] > peak)
            peak = hold_frames[b];
      return peak;
   endfunction

   // advance the press counters by one item and work out its report
   function automatic frame_report_type resolve_frame(input logic kind,
                                                      input brdr_pkg::mask_type pressed);
      frame_report_type    r;
      brdr_pkg::count_type s_down, s_left, s_right, s_up, best, t;
      int                  b;
      r = '0;
      if (kind == brdr_pkg::KIND_CLEAR) begin
         for (b = 0; b < brdr_pkg::BUTTONS; b++)
            hold_frames[b] = '0;
         return r;
      end
      for (b = 0; b < brdr_pkg::BUTTONS; b++) begin
         if (pressed[b]) begin
            if (hold_frames[b] != brdr_pkg::HOLD_MAX)
               hold_frames[b] = hold_frames[b] + 1'b1;
         end else begin
            if (hold_frames[b] != '0)
               r.released[b] = 1'b1;
            hold_frames[b] = '0;
         end
         t = hold_frames[b];
         if (t != '0) begin
            r.held[b] = 1'b1;
            if (t == brdr_pkg::count_type'(1)) begin
               r.triggered[b] = 1'b1;
               r.repeated[b]  = 1'b1;
            end else if (repeat_every != '0 && t >= start_delay &&
                         t % repeat_every == '0) begin
               r.repeated[b] = 1'b1;
            end
         end
      end
      s_down  = group_peak(down_set);
      s_left  = group_peak(left_set);
      s_right = group_peak(right_set);
      s_up    = group_peak(up_set);
      // opposed pairs cancel both directions
      if (!(s_down != '0 && s_up != '0) && !(s_left != '0 && s_right != '0)) begin
         best = '0;
         if (s_down != '0 && (best == '0 || s_down < best)) begin
            r.dir_four = brdr_pkg::DIR_DOWN;
            best = s_down;
         end
         if (s_left != '0 && (best == '0 || s_left < best)) begin
            r.dir_four = brdr_pkg::DIR_LEFT;
            best = s_left;
         end
         if (s_right != '0 && (best == '0 || s_right < best)) begin
            r.dir_four = brdr_pkg::DIR_RIGHT;
            best = s_right;
         end
         if (s_up != '0 && (best == '0 || s_up < best)) begin
            r.dir_four = brdr_pkg::DIR_UP;
            best = s_up;
         end
         r.dir_eight = r.dir_four;
         if (s_up != '0 && s_right != '0)
            r.dir_eight = brdr_pkg::DIR_UP_RIGHT;
         else if (s_up != '0 && s_left != '0)
            r.dir_eight = brdr_pkg::DIR_UP_LEFT;
         else if (s_down != '0 && s_right != '0)
            r.dir_eight = brdr_pkg::DIR_DOWN_RIGHT;
         else if (s_down != '0 && s_left != '0)
            r.dir_eight = brdr_pkg::DIR_DOWN_LEFT;
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      frame_report_type want, got;
      int               b;
      if (reset) begin
         for (b = 0; b < brdr_pkg::BUTTONS; b++)
            hold_frames[b] = '0;
         start_delay  = brdr_pkg::RST_START_DELAY;
         repeat_every = brdr_pkg::RST_PERIOD;
         down_set     = brdr_pkg::RST_DOWN_MASK;
         left_set     = brdr_pkg::RST_LEFT_MASK;
         right_set    = brdr_pkg::RST_RIGHT_MASK;
         up_set       = brdr_pkg::RST_UP_MASK;
         expected_reports.delete();
         fail_count   = 0;
         report_seq   = 0;
      end else begin
         // retire the oldest expectation before queuing a new one
         if (rsp_valid && rsp_ready) begin
            got.held      = rsp_held_mask;
            got.triggered = rsp_triggered_mask;
            got.repeated  = rsp_repeated_mask;
            got.released  = rsp_released_mask;
            got.dir_four  = rsp_dir_four;
            got.dir_eight = rsp_dir_eight;
            if (expected_reports.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("report %0d arrived with nothing expected: held %h trig %h",
                           report_seq, got.held, got.triggered);
            end else begin
               want = expected_reports.pop_front();
               if (got.held !== want.held || got.triggered !== want.triggered ||
                   got.repeated !== want.repeated || got.released !== want.released ||
                   got.dir_four !== want.dir_four || got.dir_eight !== want.dir_eight) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("report %0d: expected %h %h %h %h %0d %0d, got %h %h %h %h %0d %0d",
                              report_seq, want.held, want.triggered, want.repeated,
                              want.released, want.dir_four, want.dir_eight, got.held,
                              got.triggered, got.repeated, got.released, got.dir_four,
                              got.dir_eight);
               end
            end
            report_seq++;
         end
         if (req_valid && req_ready)
            expected_reports.insert(expected_reports.size(),
                                    resolve_frame(req_kind, req_pressed_buttons));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               brdr_pkg::CSR_START_DELAY: start_delay  = csr_data;
               brdr_pkg::CSR_PERIOD:      repeat_every = csr_data;
               brdr_pkg::CSR_DOWN_MASK:   down_set     = csr_data;
               brdr_pkg::CSR_LEFT_MASK:   left_set     = csr_data;
               brdr_pkg::CSR_RIGHT_MASK:  right_set    = csr_data;
               brdr_pkg::CSR_UP_MASK:     up_set       = csr_data;
               default: ;
            endcase
         end
      end
      mismatch_total   <= fail_count;
      frames_in_flight <= expected_reports.size();
   end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
module tb_top;

   // register indexes with no register behind them; writes must be dropped
   localparam logic [brdr_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [brdr_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 88;
   localparam int HOLD_OFF_CYCLES = 600;
   // drain wait sized for the slowest item, in which every button also runs the remainder
   localparam int DRAIN_CYCLES    = 300;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic                           req_kind = brdr_pkg::KIND_TICK;
   brdr_pkg::mask_type             req_pressed_buttons = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   brdr_pkg::mask_type             rsp_held_mask;
   brdr_pkg::mask_type             rsp_triggered_mask;
   brdr_pkg::mask_type             rsp_repeated_mask;
   brdr_pkg::mask_type             rsp_released_mask;
   brdr_pkg::dir_type              rsp_dir_four;
   brdr_pkg::dir_type              rsp_dir_eight;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [brdr_pkg::CSR_IDX_W-1:0] csr_index = brdr_pkg::CSR_START_DELAY;
   logic [15:0]                    csr_data = '0;

   int unsigned mismatch_total;
   int unsigned frames_in_flight;

   // buttons the simulated player keeps down from one frame to the next
   brdr_pkg::mask_type held_pattern = '0;
   // set by the stimulus to make the receiver park for a long stretch
   logic               hold_off_pending = 1'b0;

   always #5 clock = ~clock;

   button_repeat_and_direction_resolver_top u_dut (.*);

   brdr_frame_checker u_checker (.*);

   // Mostly back-to-back, often a short gap, now and then a long pause.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 4);
      return $urandom_range(20, 120);
   endfunction

   // Direction group: empty, all buttons, a single button or a sparse set.
   function automatic logic [15:0] random_group();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2, 3, 4: return 16'd1 << $urandom_range(0, brdr_pkg::BUTTONS - 1);
         default: return 16'($urandom & $urandom & $urandom);
      endcase
   endfunction

   // Offer one item, hold it until taken, then idle for a random gap.
   // Valid is only dropped when a gap follows, so back-to-back items keep it high.
   task automatic send_item(input logic kind, input brdr_pkg::mask_type pressed);
      int unsigned gap;
      req_valid           <= 1'b1;
      req_kind            <= kind;
      req_pressed_buttons <= pressed;
      do @(posedge clock); while (!req_ready);
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_frame(input brdr_pkg::mask_type pressed);
      send_item(brdr_pkg::KIND_TICK, pressed);
   endtask

   // Drop valid and wait until every report has come back.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (frames_in_flight != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [brdr_pkg::CSR_IDX_W-1:0] idx,
                            input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Load all six registers back-to-back, plus junk to the spare indexes.
   task automatic program_regs(input logic [15:0] delay, input logic [15:0] period,
                               input logic [15:0] dn, input logic [15:0] lf,
                               input logic [15:0] rt, input logic [15:0] up);
      write_reg(CSR_SPARE_LO, 16'($urandom));
      write_reg(brdr_pkg::CSR_START_DELAY, delay);
      write_reg(brdr_pkg::CSR_PERIOD, period);
      write_reg(brdr_pkg::CSR_DOWN_MASK, dn);
      write_reg(brdr_pkg::CSR_LEFT_MASK, lf);
      write_reg(brdr_pkg::CSR_RIGHT_MASK, rt);
      write_reg(brdr_pkg::CSR_UP_MASK, up);
      write_reg(CSR_SPARE_HI, 16'($urandom));
      csr_valid <= 1'b0;
   endtask

   // Mostly a slowly evolving set of held buttons so that counters climb
   // past the repeat delay; some noise frames, some release-all, some clears.
   task automatic random_frame();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 3) begin
         held_pattern = '0;
         send_item(brdr_pkg::KIND_CLEAR, brdr_pkg::mask_type'($urandom));
      end else if (r < 10) begin
         send_frame(brdr_pkg::mask_type'($urandom));
      end else begin
         if (r < 13)
            held_pattern = '0;
         else
            held_pattern ^= brdr_pkg::mask_type'($urandom & $urandom & $urandom & $urandom);
         send_frame(held_pattern);
      end
   endtask

   initial begin : stimulus
      int phase, n;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset register values: down, left, right, up on buttons 0..3.
      send_frame(16'h0000);
      send_frame(16'h0001);   // down alone, first frame
      send_frame(16'h0005);   // right joins: shorter press wins dir_four
      send_frame(16'h0004);   // release down
      send_frame(16'h0006);   // left against right cancels
      send_frame(16'h000A);   // up and left
      send_frame(16'h0008);
      send_frame(16'h0009);   // up against down cancels
      send_frame(16'h000C);   // up and right
      send_frame(16'hFFFF);
      send_frame(16'hFFFF);
      send_item(brdr_pkg::KIND_CLEAR, 16'hFFFF);   // clear while buttons are held
      send_frame(16'hFFFF);
      send_frame(16'h0000);   // release everything at once
      send_item(brdr_pkg::KIND_CLEAR, 16'h0000);
      settle();

      // Zero delay and zero period: only the first frame repeats.
      program_regs(16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
      send_frame(16'h8000);
      send_frame(16'h8000);
      send_frame(16'h8000);
      settle();

      // Repeat on every frame, four-button groups.
      program_regs(16'h0001, 16'h0001, 16'h000F, 16'h00F0, 16'h0F00, 16'hF000);
      send_frame(16'h0021);   // down and left
      send_frame(16'h0021);
      send_frame(16'h8021);   // up joins against down
      send_frame(16'h0200);   // right alone, three releases
      settle();

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: program_regs(16'h0001, 16'h0001, random_group(), random_group(),
                            random_group(), random_group());
            1: program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
            2: program_regs(16'h0000, 16'h0000, random_group(), random_group(),
                            random_group(), random_group());
            default: program_regs(16'($urandom_range(0, 40)), 16'($urandom_range(0, 8)),
                                  random_group(), random_group(), random_group(),
                                  random_group());
         endcase
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            // park the receiver once mid-run so the block backs up
            if (phase == 3 && n == 30)
               hold_off_pending = 1'b1;
            random_frame();
         end
         settle();
      end

      // let any stray report surface before the verdict
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_total == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Receiver: random stalls, stretches of steady ready, and one long hold-off.
   initial begin : receiver
      int unsigned stall;
      while (reset)
         @(posedge clock);
      forever begin
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            stall = pick_gap();
            if (stall != 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 9) == 0)
            repeat (200) @(posedge clock);
         else
            repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   initial begin : watchdog
      #10ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: files.f
src/brdr_pkg.sv
src/button_repeat_and_direction_resolver_top.sv
src/brdr_checker.sv
tb/brdr_frame_checker.sv
tb/tb_top.sv
